@@ rtl/core/lgre_pkg.sv @@
package lgre_pkg;

  // fixed field widths of the config word and the stream payloads
  localparam int DATA_W      = 64;
  localparam int CFG_W       = 7;
  localparam int COUNT_W     = 7;
  localparam int OUT_TDATA_W = 72;

  // default and upper bound of the row width in cells
  localparam int MAX_WIDTH_DEF = 64;

  // result queue depth, a power of two of at least four
  localparam int OUT_DEPTH = 4;

  // push codes for the result queue
  localparam logic [1:0] PUSH_NONE = 2'd0;
  localparam logic [1:0] PUSH_ONE  = 2'd1;
  localparam logic [1:0] PUSH_TWO  = 2'd2;

  typedef struct packed {
    logic               eog;
    logic [COUNT_W-1:0] live;
    logic [DATA_W-1:0]  cells;
  } result_t;

  typedef struct packed {
    logic [1:0] n;
    result_t    first;
    result_t    second;
  } push_t;

endpackage

@@ rtl/core/life_generation_row_engine_top.sv @@
// Life (B3/S23) row engine: computes one generation of a grid that is
// grid_width cells wide, one row per input transfer, top row first, with
// tlast on the bottom row. Cells outside the grid are dead. Each row is
// masked to the width on arrival; the first row of a grid gives no result
// unless it is also the bottom row (then it gives itself, with tlast),
// every later row gives the next state of the row above it, and a later
// bottom row gives two results (row above, then itself, the latter with
// tlast). A grid of H rows thus yields H results. The block takes one row
// per cycle while the queue has room: all cells are updated in parallel
// in one pass between the input register and a four-entry result queue,
// and the sustained rate is one row per cycle while out_tready is high,
// limited by the one-result-per-cycle output port (the extra result of a
// bottom row is absorbed by the queue). grid_width may only be written
// while the block is idle; widths above MAX_WIDTH saturate.
module life_generation_row_engine_top
  import lgre_pkg::*;
#(
  parameter int MAX_WIDTH = MAX_WIDTH_DEF
) (
  input  logic                   clk,
  input  logic                   rst_n,
  // configuration: grid_width
  input  logic                   cfg_wen,
  input  logic [CFG_W-1:0]       cfg_wdata,
  // input rows
  input  logic                   in_tvalid,
  output logic                   in_tready,
  input  logic [DATA_W-1:0]      in_tdata,   // [63:0] row_cells
  input  logic                   in_tlast,   // last_row
  // results
  output logic                   out_tvalid,
  input  logic                   out_tready,
  output logic [OUT_TDATA_W-1:0] out_tdata,  // [63:0] next_cells, [70:64] live_count, [71] 0
  output logic                   out_tlast   // end_of_grid
);

  localparam int QAW = $clog2(OUT_DEPTH);

  // width mask, one bit per cell in use
  logic [MAX_WIDTH-1:0] width_mask_r;
  logic [MAX_WIDTH-1:0] width_mask_nxt;

  // input register
  logic                 s1_valid_r;
  logic [MAX_WIDTH-1:0] s1_row_r;
  logic                 s1_last_r;

  // rows held from earlier in the grid
  logic [MAX_WIDTH-1:0] older_row_r;
  logic [MAX_WIDTH-1:0] middle_row_r;
  logic [1:0]           rows_held_r;

  logic                 in_xfer;
  logic                 s1_go;
  logic                 held_none;
  logic                 q_room;

  logic [MAX_WIDTH-1:0] above_b;
  logic [MAX_WIDTH-1:0] cells_a;
  logic [MAX_WIDTH-1:0] cells_b;
  logic [COUNT_W-1:0]   live_a;
  logic [COUNT_W-1:0]   live_b;

  push_t                push;
  result_t              head;
  logic                 q_not_empty;
  logic [QAW:0]         q_level;
  logic                 out_xfer;

  // decode the width written on the config port, saturated to MAX_WIDTH
  always_comb begin
    for (int i = 0; i < MAX_WIDTH; i++) begin
      width_mask_nxt[i] = (CFG_W'(i) < cfg_wdata);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_mask_r <= '1;
    end else if (cfg_wen) begin
      width_mask_r <= width_mask_nxt;
    end
  end

  // the input stage advances only when the queue has room for two results
  assign q_room    = (q_level <= (QAW+1)'(OUT_DEPTH - 2));
  assign s1_go     = s1_valid_r && q_room;
  assign in_tready = !s1_valid_r || s1_go;
  assign in_xfer   = in_tvalid && in_tready;
  assign held_none = (rows_held_r == 2'd0);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_xfer) begin
      s1_valid_r <= 1'b1;
    end else if (s1_go) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      s1_row_r  <= in_tdata[MAX_WIDTH-1:0] & width_mask_r;
      s1_last_r <= in_tlast;
    end
  end

  // row history; a held count of three acts as two
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      older_row_r  <= '0;
      middle_row_r <= '0;
      rows_held_r  <= 2'd0;
    end else if (s1_go) begin
      if (s1_last_r) begin
        // end of grid, next row starts a new one
        older_row_r  <= '0;
        middle_row_r <= '0;
        rows_held_r  <= 2'd0;
      end else if (held_none) begin
        older_row_r  <= '0;
        middle_row_r <= s1_row_r;
        rows_held_r  <= 2'd1;
      end else begin
        older_row_r  <= middle_row_r;
        middle_row_r <= s1_row_r;
        rows_held_r  <= 2'd2;
      end
    end
  end

  // unit a: the row above the current one, with both neighbors present
  lgre_row_evolve #(
    .MAX_WIDTH (MAX_WIDTH)
  ) u_evolve_a (
    .above (older_row_r),
    .here  (middle_row_r),
    .below (s1_row_r),
    .mask  (width_mask_r),
    .cells (cells_a),
    .live  (live_a)
  );

  // unit b: the current row with a dead row below (bottom row only)
  assign above_b = held_none ? '0 : middle_row_r;

  lgre_row_evolve #(
    .MAX_WIDTH (MAX_WIDTH)
  ) u_evolve_b (
    .above (above_b),
    .here  (s1_row_r),
    .below ('0),
    .mask  (width_mask_r),
    .cells (cells_b),
    .live  (live_b)
  );

  // results into the queue
  always_comb begin
    push              = '0;
    push.second.cells = DATA_W'(cells_b);
    push.second.live  = live_b;
    push.second.eog   = 1'b1;
    if (s1_go) begin
      if (held_none) begin
        // single-row grid emits itself, otherwise the first row waits
        if (s1_last_r) begin
          push.n     = PUSH_ONE;
          push.first = push.second;
        end
      end else begin
        push.n           = s1_last_r ? PUSH_TWO : PUSH_ONE;
        push.first.cells = DATA_W'(cells_a);
        push.first.live  = live_a;
        push.first.eog   = 1'b0;
      end
    end
  end

  lgre_out_fifo #(
    .DEPTH (OUT_DEPTH)
  ) u_out_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .pop       (out_xfer),
    .head      (head),
    .not_empty (q_not_empty),
    .level     (q_level)
  );

  assign out_tvalid = q_not_empty;
  assign out_xfer   = out_tvalid && out_tready;
  assign out_tdata  = {1'b0, head.live, head.cells};
  assign out_tlast  = head.eog;

endmodule

@@ rtl/core/lgre_row_evolve.sv @@
module lgre_row_evolve
  import lgre_pkg::*;
#(
  parameter int MAX_WIDTH = MAX_WIDTH_DEF
) (
  input  logic [MAX_WIDTH-1:0] above,
  input  logic [MAX_WIDTH-1:0] here,
  input  logic [MAX_WIDTH-1:0] below,
  input  logic [MAX_WIDTH-1:0] mask,
  output logic [MAX_WIDTH-1:0] cells,
  output logic [COUNT_W-1:0]   live
);

  localparam int GROUPS = (MAX_WIDTH + 7) / 8;
  localparam int PAD_W  = GROUPS * 8;

  logic [MAX_WIDTH+1:0] a_p;
  logic [MAX_WIDTH+1:0] h_p;
  logic [MAX_WIDTH+1:0] b_p;
  logic [MAX_WIDTH-1:0] nxt;
  logic [PAD_W-1:0]     cells_pad;
  logic [3:0]           grp_cnt [GROUPS];

  // dead border on both sides
  assign a_p = {1'b0, above & mask, 1'b0};
  assign h_p = {1'b0, here & mask, 1'b0};
  assign b_p = {1'b0, below & mask, 1'b0};

  always_comb begin
    logic [3:0] nb;
    nb  = '0;
    nxt = '0;
    for (int i = 0; i < MAX_WIDTH; i++) begin
      nb = 4'(a_p[i]) + 4'(a_p[i+1]) + 4'(a_p[i+2])
         + 4'(h_p[i]) + 4'(h_p[i+2])
         + 4'(b_p[i]) + 4'(b_p[i+1]) + 4'(b_p[i+2]);
      // birth on three, survival on two or three
      nxt[i] = (nb == 4'd3) || (h_p[i+1] && (nb == 4'd2));
    end
  end

  assign cells     = nxt & mask;
  assign cells_pad = PAD_W'(cells);

  // population count: byte sums, then a sum over the bytes
  always_comb begin
    logic [COUNT_W-1:0] acc;
    acc = '0;
    for (int g = 0; g < GROUPS; g++) begin
      grp_cnt[g] = '0;
      for (int k = 0; k < 8; k++) begin
        grp_cnt[g] = grp_cnt[g] + 4'(cells_pad[g*8+k]);
      end
    end
    for (int g = 0; g < GROUPS; g++) begin
      acc = acc + COUNT_W'(grp_cnt[g]);
    end
    live = acc;
  end

endmodule

@@ rtl/core/lgre_out_fifo.sv @@
module lgre_out_fifo
  import lgre_pkg::*;
#(
  parameter int DEPTH = OUT_DEPTH
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  push_t                  push,
  input  logic                   pop,
  output result_t                head,
  output logic                   not_empty,
  output logic [$clog2(DEPTH):0] level
);

  localparam int AW = $clog2(DEPTH);

  result_t         mem [DEPTH];
  logic [AW-1:0]   wr_ptr_r;
  logic [AW-1:0]   wr_ptr_nxt;
  logic [AW-1:0]   rd_ptr_r;
  logic [AW-1:0]   rd_ptr_nxt;
  logic [AW:0]     level_r;
  logic [AW:0]     level_nxt;
  logic [AW:0]     push_n;

  always_comb begin
    case (push.n)
      PUSH_ONE: push_n = (AW+1)'(1);
      PUSH_TWO: push_n = (AW+1)'(2);
      default:  push_n = '0;
    endcase
  end

  assign wr_ptr_nxt = wr_ptr_r + push_n[AW-1:0];
  assign rd_ptr_nxt = rd_ptr_r + AW'(pop);
  assign level_nxt  = level_r + push_n - (AW+1)'(pop);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      level_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      level_r  <= level_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push.n == PUSH_ONE || push.n == PUSH_TWO) begin
      mem[wr_ptr_r] <= push.first;
    end
    if (push.n == PUSH_TWO) begin
      mem[wr_ptr_r + AW'(1)] <= push.second;
    end
  end

  assign head      = mem[rd_ptr_r];
  assign not_empty = (level_r != '0);
  assign level     = level_r;

endmodule

@@ bench/tb_life_generation_row_engine_top.sv @@
module tb_life_generation_row_engine_top;
  import lgre_pkg::*;

  // one row waiting to be offered on the input stream
  typedef struct {
    logic [DATA_W-1:0] cells;
    logic              last;
  } row_item_t;

  localparam int QUIET_LIMIT = 4000;  // cycles with no transfer before giving up
  localparam int SETTLE_CYCLES = 4;   // pipeline latency plus margin

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_wen = 1'b0;
  logic [CFG_W-1:0] cfg_wdata = '0;
  logic in_tvalid = 1'b0;
  logic in_tready;
  logic [DATA_W-1:0] in_tdata = '0;   // [63:0] row_cells
  logic in_tlast = 1'b0;              // last_row
  logic out_tvalid;
  logic out_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] out_tdata;  // [63:0] next_cells, [70:64] live_count, [71] 0
  logic out_tlast;                    // end_of_grid

  life_generation_row_engine_top uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_wen    (cfg_wen),
    .cfg_wdata  (cfg_wdata),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

  always #5 clk = ~clk;

  // rows queued by the stimulus, rows still to come out of the block
  row_item_t rows_to_send[$];
  result_t   next_rows_due[$];

  int rows_pushed = 0;
  int rows_taken = 0;
  int errors = 0;
  int quiet_cycles = 0;
  int send_idle_pct = 27;
  int recv_idle_pct = 51;
  logic row_taken = 1'b0;  // input transfer happened at the last rising edge

  // mirror of the block's generation state
  int                row_span = MAX_WIDTH_DEF;
  logic [DATA_W-1:0] older_row = '0;
  logic [DATA_W-1:0] middle_row = '0;
  logic [1:0]        rows_held = '0;

  // width settings of the random segments, -1 picks one at random
  int seg_widths[12] = '{37, 64, 1, 127, 3, 0, 64, 2, 63, -1, -1, 64};

  function automatic logic [DATA_W-1:0] span_mask(int span);
    if (span >= DATA_W) return '1;
    return (64'd1 << span) - 64'd1;
  endfunction

  // a cell outside the 64-bit row is dead
  function automatic int cell_of(logic [DATA_W-1:0] r, int idx);
    if (idx < 0 || idx >= DATA_W) return 0;
    return int'(r[idx]);
  endfunction

  // b3/s23 update of one row given its vertical neighbours
  function automatic logic [DATA_W-1:0] next_generation(logic [DATA_W-1:0] above,
                                                        logic [DATA_W-1:0] here,
                                                        logic [DATA_W-1:0] below,
                                                        int span);
    logic [DATA_W-1:0] m;
    logic [DATA_W-1:0] res;
    int n;
    m = span_mask(span);
    above = above & m;
    here = here & m;
    below = below & m;
    res = '0;
    for (int i = 0; i < DATA_W; i++) begin
      if (i < span) begin
        n = cell_of(above, i - 1) + cell_of(above, i) + cell_of(above, i + 1)
          + cell_of(here, i - 1) + cell_of(here, i + 1)
          + cell_of(below, i - 1) + cell_of(below, i) + cell_of(below, i + 1);
        if (n == 3 || (here[i] && n == 2)) res[i] = 1'b1;
      end
    end
    return res & m;
  endfunction

  function automatic result_t make_result(logic [DATA_W-1:0] cells, logic eog);
    result_t r;
    int cnt;
    cnt = 0;
    for (int i = 0; i < DATA_W; i++) cnt += int'(cells[i]);
    r.cells = cells;
    r.live = COUNT_W'(cnt);
    r.eog = eog;
    return r;
  endfunction

  // advance the mirror by one accepted row and queue the rows it completes
  task automatic step_life_row(logic [DATA_W-1:0] raw, logic last);
    logic [DATA_W-1:0] row;
    row = raw & span_mask(row_span);
    if (rows_held == 2'd0) begin
      if (last) begin
        // single-row grid: dead rows above and below
        next_rows_due.push_back(make_result(next_generation('0, row, '0, row_span), 1'b1));
        older_row = '0;
        middle_row = '0;
      end else begin
        older_row = '0;
        middle_row = row;
        rows_held = 2'd1;
      end
    end else begin
      next_rows_due.push_back(
        make_result(next_generation(older_row, middle_row, row, row_span), 1'b0));
      if (last) begin
        // bottom row closes the grid and clears the history
        next_rows_due.push_back(make_result(next_generation(middle_row, row, '0, row_span), 1'b1));
        older_row = '0;
        middle_row = '0;
        rows_held = 2'd0;
      end else begin
        older_row = middle_row;
        middle_row = row;
        rows_held = 2'd2;
      end
    end
  endtask

  task automatic report_mismatch(string msg);
    errors++;
    if (errors <= 10) $display("%s", msg);
  endtask

  // sample both streams and the config port at the rising edge
  always @(posedge clk) begin : stream_monitor
    result_t want;
    logic progress;
    progress = 1'b0;
    if (rst_n) begin
      if (cfg_wen) begin
        // widths above the maximum saturate
        row_span = (int'(cfg_wdata) > MAX_WIDTH_DEF) ? MAX_WIDTH_DEF : int'(cfg_wdata);
        progress = 1'b1;
      end
      if (in_tvalid && in_tready) begin
        step_life_row(in_tdata, in_tlast);
        rows_taken++;
        progress = 1'b1;
      end
      if (out_tvalid && out_tready) begin
        progress = 1'b1;
        if (next_rows_due.size() == 0) begin
          report_mismatch($sformatf("unexpected result: cells %h live %0d last %b",
                                    out_tdata[DATA_W-1:0], out_tdata[DATA_W +: COUNT_W],
                                    out_tlast));
        end else begin
          want = next_rows_due.pop_front();
          if (out_tdata[DATA_W-1:0] !== want.cells)
            report_mismatch($sformatf("next_cells: expected %h, got %h",
                                      want.cells, out_tdata[DATA_W-1:0]));
          if (out_tdata[DATA_W +: COUNT_W] !== want.live)
            report_mismatch($sformatf("live_count: expected %0d, got %0d",
                                      want.live, out_tdata[DATA_W +: COUNT_W]));
          if (out_tlast !== want.eog)
            report_mismatch($sformatf("end_of_grid: expected %b, got %b", want.eog, out_tlast));
          if (out_tdata[OUT_TDATA_W-1] !== 1'b0)
            report_mismatch($sformatf("pad bit: expected 0, got %b", out_tdata[OUT_TDATA_W-1]));
        end
      end
    end
    quiet_cycles <= progress ? 0 : quiet_cycles + 1;
    row_taken <= rst_n && in_tvalid && in_tready;
  end

  // row driver: holds a row until its transfer, then offers the next one
  always @(negedge clk) begin : row_driver
    row_item_t item;
    if (rst_n) begin
      if (in_tvalid && !row_taken) begin
        // still waiting for tready, keep the row steady
      end else if (rows_to_send.size() > 0 && $urandom_range(0, 99) >= send_idle_pct) begin
        item = rows_to_send.pop_front();
        in_tvalid <= 1'b1;
        in_tdata <= item.cells;
        in_tlast <= item.last;
      end else begin
        in_tvalid <= 1'b0;
      end
    end
  end

  // result backpressure
  always @(negedge clk) begin
    out_tready <= rst_n && ($urandom_range(0, 99) >= recv_idle_pct);
  end

  task automatic push_row(logic [DATA_W-1:0] cells, logic last);
    row_item_t item;
    item.cells = cells;
    item.last = last;
    rows_to_send.push_back(item);
    rows_pushed++;
  endtask

  // sender stays quiet until every queued row is taken and every result is out
  task automatic drain();
    while (rows_taken != rows_pushed || next_rows_due.size() != 0) @(negedge clk);
  endtask

  // width writes only while idle, after the pipeline has settled
  task automatic set_grid_width(int value);
    drain();
    repeat (SETTLE_CYCLES) @(negedge clk);
    cfg_wen <= 1'b1;
    cfg_wdata <= CFG_W'(value);
    @(negedge clk);
    cfg_wen <= 1'b0;
    @(negedge clk);
  endtask

  function automatic logic [DATA_W-1:0] pick_row();
    case ($urandom_range(0, 9))
      0:       return '1;
      1:       return '0;
      2, 3:    return {$urandom, $urandom} & {$urandom, $urandom} & {$urandom, $urandom};
      4:       return {$urandom, $urandom} | {$urandom, $urandom};
      default: return {$urandom, $urandom};
    endcase
  endfunction

  // watchdog: no transfer of any kind for too long
  initial begin
    while (quiet_cycles < QUIET_LIMIT) @(posedge clk);
    $display("tb_life_generation_row_engine_top: FAIL");
    $finish;
  end

  initial begin
    int height;
    int seg_rows;
    int w;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // directed part at the reset width of 64
    push_row('1, 1'b1);                       // single-row grid, all alive
    push_row('0, 1'b1);                       // single-row grid, all dead
    push_row(64'h0000_0000_0001_0000, 1'b0);  // vertical blinker
    push_row(64'h0000_0000_0001_0000, 1'b0);
    push_row(64'h0000_0000_0001_0000, 1'b1);
    push_row(64'h8000_0000_0000_0001, 1'b0);  // activity on both row edges
    push_row(64'hC000_0000_0000_0003, 1'b0);
    push_row(64'h8000_0000_0000_0001, 1'b1);
    push_row(64'hAAAA_AAAA_AAAA_AAAA, 1'b0);  // alternating patterns
    push_row(64'h5555_5555_5555_5555, 1'b1);
    push_row('1, 1'b0);                       // full grid, only the corner cells survive
    push_row('1, 1'b1);

    // zero width: every result row is dead
    set_grid_width(0);
    push_row('1, 1'b0);
    push_row('1, 1'b1);

    // width above the maximum saturates
    set_grid_width(127);
    push_row(64'hFFFF_0000_FFFF_0000, 1'b0);
    push_row('1, 1'b1);

    // one-cell-wide grid
    set_grid_width(1);
    push_row('1, 1'b0);
    push_row('1, 1'b0);
    push_row('1, 1'b1);

    // width changes while a grid is half done
    set_grid_width(10);
    push_row('1, 1'b0);
    set_grid_width(5);
    push_row('1, 1'b0);
    push_row(64'h0000_0000_0000_0015, 1'b1);

    // random part: three idle mixes, four width settings each
    for (int mode = 0; mode < 3; mode++) begin
      for (int seg = 0; seg < 4; seg++) begin
        w = seg_widths[mode * 4 + seg];
        if (w < 0) w = $urandom_range(1, 64);
        set_grid_width(w);
        // change the idle mix only once the block is idle
        send_idle_pct = (mode == 0) ? 27 : (mode == 1) ? 51 : 0;
        recv_idle_pct = (mode == 0) ? 51 : (mode == 1) ? 27 : 0;
        seg_rows = 0;
        while (seg_rows < 80) begin
          height = ($urandom_range(0, 9) == 0) ? 1 : $urandom_range(2, 7);
          for (int r = 0; r < height; r++) push_row(pick_row(), r == height - 1);
          seg_rows += height;
          // now and then the sender waits for every result to come out
          if ($urandom_range(0, 24) == 0) drain();
        end
      end
    end

    drain();
    repeat (10) @(negedge clk);
    if (errors == 0 && next_rows_due.size() == 0) begin
      $display("tb_life_generation_row_engine_top: PASS");
    end else begin
      $display("tb_life_generation_row_engine_top: FAIL");
    end
    $finish;
  end

endmodule

@@ life_generation_row_engine_top.f @@
rtl/core/lgre_pkg.sv
rtl/core/lgre_row_evolve.sv
rtl/core/lgre_out_fifo.sv
rtl/core/life_generation_row_engine_top.sv
bench/tb_life_generation_row_engine_top.sv
